FILE: hw/rtl/csv_record_tokenizer_top_defines.svh
// ---------------------------------------------------------------------------
// csv_record_tokenizer_top_defines
// Assertion macros for the CSV record tokenizer.
// ---------------------------------------------------------------------------
`ifndef CSV_RECORD_TOKENIZER_TOP_DEFINES_SVH
`define CSV_RECORD_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication
`define CRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/crt_pkg.sv
// ---------------------------------------------------------------------------
// crt_pkg
// Types and constants of the CSV record tokenizer.
// ---------------------------------------------------------------------------
package crt_pkg;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VTAB  = 8'h0B;

  localparam logic [2:0] REG_DELIMITER   = 3'd0;
  localparam logic [2:0] REG_QUOTE       = 3'd1;
  localparam logic [2:0] REG_ESCAPE      = 3'd2;
  localparam logic [2:0] REG_ESCAPE_MODE = 3'd3;
  localparam logic [2:0] REG_TERM_FIRST  = 3'd4;
  localparam logic [2:0] REG_TERM_SECOND = 3'd5;
  localparam logic [2:0] REG_TERM_LENGTH = 3'd6;
  localparam logic [2:0] REG_SPACE_OPTS  = 3'd7;

  localparam logic [1:0] TERM_LEN_TWO = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        field_end;
    logic        record_end;
    logic        field_quoted;
    logic        discard_field;
    logic        parse_error;
    logic [31:0] line_number;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [7:0] delimiter_char;
    logic [7:0] quote_char;
    logic [7:0] escape_char;
    logic       escape_mode;
    logic [7:0] term_first;
    logic [7:0] term_second;
    logic [1:0] term_length;
    logic [1:0] space_options;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    delimiter_char: 8'd44,
    quote_char:     8'd34,
    escape_char:    8'd92,
    escape_mode:    1'b0,
    term_first:     8'd10,
    term_second:    8'd0,
    term_length:    2'd1,
    space_options:  2'd0
  };

endpackage

FILE: hw/rtl/csv_record_tokenizer_top.sv
// ---------------------------------------------------------------------------
// csv_record_tokenizer_top
// Results of an item are registered and shown in the cycle after its transfer.
// One byte per cycle; input stalls until at most one result is left and it is taken.
// Reset: synchronous, clears parser state, line count to one, registers to defaults.
// ---------------------------------------------------------------------------
`include "csv_record_tokenizer_top_defines.svh"

module csv_record_tokenizer_top
  import crt_pkg::*;
#(
  parameter int unsigned LINE_COUNT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  in_item_t   item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result
);

  typedef enum logic [2:0] {
    PH_REC    = 3'd0,
    PH_FIELD  = 3'd1,
    PH_UNQS   = 3'd2,
    PH_UNQ    = 3'd3,
    PH_QUOTED = 3'd4,
    PH_AQUOTE = 3'd5,
    PH_AESC   = 3'd6,
    PH_SKIP   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RAW  = 2'd0,
    KIND_TERM = 2'd1,
    KIND_HELD = 2'd2
  } kind_t;

  typedef struct packed {
    phase_t                     phase;
    logic                       pending;
    logic                       quoted;
    logic [LINE_COUNT_BITS-1:0] lines;
  } ctx_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] r;
    logic [RES_CNT_W-1:0]      cnt;
  } bundle_t;

  typedef struct packed {
    ctx_t    c;
    bundle_t bd;
    logic    refeed;
  } fr_t;

  function automatic fr_t push(fr_t s, logic [7:0] b, logic valid, logic fe, logic re,
                               logic disc, logic err);
    fr_t     o;
    result_t r;
    o = s;
    r.out_byte      = valid ? b : 8'd0;
    r.byte_valid    = valid;
    r.field_end     = fe;
    r.record_end    = re;
    r.field_quoted  = fe & s.c.quoted;
    r.discard_field = disc;
    r.parse_error   = err;
    r.line_number   = 32'(s.c.lines);
    r.last          = 1'b0;
    if (s.bd.cnt < RES_CNT_W'(MAX_RESULTS)) begin
      o.bd.r[s.bd.cnt[RES_IDX_W-1:0]] = r;
      o.bd.cnt = s.bd.cnt + RES_CNT_W'(1);
    end
    return o;
  endfunction

  function automatic fr_t close_field(fr_t s, logic rec);
    fr_t o;
    o = push(s, 8'd0, 1'b0, 1'b1, rec, 1'b0, 1'b0);
    o.c.quoted = 1'b0;
    return o;
  endfunction

  function automatic fr_t bump(fr_t s);
    fr_t o;
    o = s;
    o.c.lines = s.c.lines + LINE_COUNT_BITS'(1);
    return o;
  endfunction

  function automatic fr_t term_content(fr_t s, cfg_t cf);
    fr_t o;
    o = push(s, cf.term_first, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    if (cf.term_length == TERM_LEN_TWO) begin
      o = push(o, cf.term_second, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    end
    o = bump(o);
    return o;
  endfunction

  function automatic fr_t feed1(fr_t s, cfg_t cf, logic [7:0] b, kind_t kind);
    fr_t  o;
    logic lit;
    logic tm;
    logic hold;
    logic q;
    logic dl;
    logic es;
    logic sp;
    o        = s;
    o.refeed = 1'b0;
    lit  = (kind != KIND_TERM);
    tm   = (kind == KIND_TERM) || ((kind == KIND_RAW) && (b == cf.term_first));
    hold = tm && (kind == KIND_RAW) && (cf.term_length == TERM_LEN_TWO);
    q    = lit && (b == cf.quote_char);
    dl   = lit && (b == cf.delimiter_char);
    es   = lit && (b == cf.escape_char);
    sp   = lit && (b != cf.delimiter_char) &&
           ((b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VTAB));
    if (s.c.phase == PH_SKIP) begin
      if (hold) begin
        o.c.pending = 1'b1;
      end else if (tm) begin
        o.c.phase = PH_REC;
      end
    end else if (cf.escape_mode) begin
      if (s.c.phase == PH_AESC) begin
        if (es || dl) begin
          o = push(o, b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
          o.c.phase = PH_UNQ;
        end else if (tm) begin
          if (hold) begin
            o.c.pending = 1'b1;
          end else begin
            o = term_content(o, cf);
            o.c.phase = PH_UNQ;
          end
        end else begin
          o.c.phase = PH_UNQ;
          o.refeed  = 1'b1;
        end
      end else if (es) begin
        o.c.phase = PH_AESC;
      end else if (tm) begin
        if (hold) begin
          o.c.pending = 1'b1;
        end else begin
          o = close_field(o, 1'b1);
          o = bump(o);
          o.c.phase = PH_REC;
        end
      end else if (dl) begin
        o = close_field(o, 1'b0);
        o.c.phase = PH_FIELD;
      end else begin
        o = push(o, b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        o.c.phase = PH_UNQ;
      end
    end else begin
      unique case (s.c.phase) inside
        PH_QUOTED: begin
          if (q) begin
            o.c.phase = PH_AQUOTE;
          end else if (tm) begin
            if (hold) begin
              o.c.pending = 1'b1;
            end else begin
              o = term_content(o, cf);
            end
          end else begin
            o = push(o, b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
          end
        end
        PH_AQUOTE: begin
          if (sp && cf.space_options[0]) begin
            o.c.phase = PH_AQUOTE;
          end else if (tm) begin
            if (hold) begin
              o.c.pending = 1'b1;
            end else begin
              o = close_field(o, 1'b1);
              o = bump(o);
              o.c.phase = PH_REC;
            end
          end else if (dl) begin
            o = close_field(o, 1'b0);
            o.c.phase = PH_FIELD;
          end else if (q) begin
            o = push(o, b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            o.c.phase = PH_QUOTED;
          end else begin
            o = push(o, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            o.c.quoted = 1'b0;
            o.c.phase  = PH_SKIP;
          end
        end
        PH_UNQS, PH_UNQ: begin
          if (tm) begin
            if (hold) begin
              o.c.pending = 1'b1;
            end else begin
              o = close_field(o, 1'b1);
              o = bump(o);
              o.c.phase = PH_REC;
            end
          end else if (dl) begin
            o = close_field(o, 1'b0);
            o.c.phase = PH_FIELD;
          end else if (q) begin
            if (cf.space_options[1] && (s.c.phase == PH_UNQS)) begin
              o = push(o, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
              o.c.quoted = 1'b1;
              o.c.phase  = PH_QUOTED;
            end else begin
              o = push(o, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
              o.c.quoted = 1'b0;
              o.c.phase  = PH_SKIP;
            end
          end else begin
            o = push(o, b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            if (!sp) begin
              o.c.phase = PH_UNQ;
            end
          end
        end
        default: begin
          if (q) begin
            o.c.quoted = 1'b1;
            o.c.phase  = PH_QUOTED;
          end else if (dl) begin
            o.c.quoted = 1'b0;
            o = close_field(o, 1'b0);
            o.c.phase = PH_FIELD;
          end else begin
            o.c.quoted = 1'b0;
            o.c.phase  = PH_UNQS;
            o.refeed   = 1'b1;
          end
        end
      endcase
    end
    return o;
  endfunction

  // one byte, including the single re-dispatch after a phase change
  function automatic fr_t feed(fr_t s, cfg_t cf, logic [7:0] b, kind_t kind);
    fr_t o;
    o = feed1(s, cf, b, kind);
    if (o.refeed) begin
      o = feed1(o, cf, b, kind);
    end
    o.refeed = 1'b0;
    return o;
  endfunction

  function automatic fr_t step_f(ctx_t c, cfg_t cf, in_item_t it);
    fr_t                  o;
    logic [RES_CNT_W-1:0] lidx;
    o.c      = c;
    o.bd     = '0;
    o.refeed = 1'b0;
    if (it.end_of_input) begin
      if (c.pending) begin
        o.c.pending = 1'b0;
        o = feed(o, cf, cf.term_first, KIND_HELD);
      end
      if ((o.c.phase != PH_REC) && (o.c.phase != PH_SKIP)) begin
        o = close_field(o, 1'b1);
      end
      o.c.phase  = PH_REC;
      o.c.quoted = 1'b0;
    end else if (c.pending) begin
      o.c.pending = 1'b0;
      if (it.data_byte == cf.term_second) begin
        o = feed(o, cf, it.data_byte, KIND_TERM);
      end else begin
        o = feed(o, cf, cf.term_first, KIND_HELD);
        o = feed(o, cf, it.data_byte, KIND_RAW);
      end
    end else begin
      o = feed(o, cf, it.data_byte, KIND_RAW);
    end
    lidx = o.bd.cnt - RES_CNT_W'(1);
    if (o.bd.cnt != '0) begin
      o.bd.r[lidx[RES_IDX_W-1:0]].last = 1'b1;
    end
    return o;
  endfunction

  cfg_t                       cfg;
  phase_t                     phase;
  logic                       term_pending;
  logic                       current_quoted;
  logic [LINE_COUNT_BITS-1:0] line_count;
  bundle_t                    res_buf;
  logic [RES_CNT_W-1:0]       res_cnt;
  logic [RES_IDX_W-1:0]       res_idx;

  ctx_t ctx;
  fr_t  step;
  logic item_fire;
  logic result_fire;

  assign ctx.phase   = phase;
  assign ctx.pending = term_pending;
  assign ctx.quoted  = current_quoted;
  assign ctx.lines   = line_count;

  always_comb begin
    step = step_f(ctx, cfg, item);
  end

  assign result_valid = (res_cnt != '0);
  assign result       = res_buf.r[res_idx];
  assign result_fire  = result_valid && !result_stall;
  assign item_stall   = !((res_cnt == '0) ||
                          ((res_cnt == RES_CNT_W'(1)) && !result_stall));
  assign item_fire    = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg            <= CFG_RESET;
      phase          <= PH_REC;
      term_pending   <= 1'b0;
      current_quoted <= 1'b0;
      line_count     <= LINE_COUNT_BITS'(1);
      res_cnt        <= '0;
      res_idx        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DELIMITER: begin
            cfg.delimiter_char <= cfg_data;
          end
          REG_QUOTE: begin
            cfg.quote_char <= cfg_data;
          end
          REG_ESCAPE: begin
            cfg.escape_char <= cfg_data;
          end
          REG_ESCAPE_MODE: begin
            cfg.escape_mode <= cfg_data[0];
            phase           <= PH_REC;
            term_pending    <= 1'b0;
            current_quoted  <= 1'b0;
          end
          REG_TERM_FIRST: begin
            cfg.term_first <= cfg_data;
            term_pending   <= 1'b0;
          end
          REG_TERM_SECOND: begin
            cfg.term_second <= cfg_data;
            term_pending    <= 1'b0;
          end
          REG_TERM_LENGTH: begin
            cfg.term_length <= cfg_data[1:0];
            term_pending    <= 1'b0;
          end
          REG_SPACE_OPTS: begin
            cfg.space_options <= cfg_data[1:0];
          end
          default: begin
            cfg <= cfg;
          end
        endcase
      end else if (item_fire) begin
        phase          <= step.c.phase;
        term_pending   <= step.c.pending;
        current_quoted <= step.c.quoted;
        line_count     <= step.c.lines;
      end
      if (item_fire) begin
        res_buf <= step.bd;
        res_cnt <= step.bd.cnt;
        res_idx <= '0;
      end else if (result_fire) begin
        res_cnt <= res_cnt - RES_CNT_W'(1);
        res_idx <= res_idx + RES_IDX_W'(1);
      end
    end
  end

  `CRT_ASSERT_NOW(a_buf_bounds, clk, rst, result_valid, (RES_CNT_W'(res_idx) + res_cnt) <= RES_CNT_W'(MAX_RESULTS), "result buffer index out of range")
  `CRT_ASSERT_NOW(a_last_final, clk, rst, result_valid && result.last, res_cnt == RES_CNT_W'(1), "last flag not on final result")
  `CRT_ASSERT_NOW(a_record_field, clk, rst, result_valid && result.record_end, result.field_end, "record end without field end")
  `CRT_ASSERT_NEXT(a_fire_shows, clk, rst, item_fire && (step.bd.cnt != '0), result_valid && (res_idx == '0), "transfer results not presented")

endmodule

FILE: tb/tb_csv_record_tokenizer_top.sv
// ---------------------------------------------------------------------------
// tb_csv_record_tokenizer_top
// Self-checking bench for the byte-serial CSV tokenizer. A queue-fed driver
// sends text bytes in random bursts. A clocked monitor runs a behavioral
// tokenizer on every accepted byte and compares each result transfer, field
// by field, against the oldest predicted token. Register settings change
// between phases while the block is idle: quote and escape parsing, one- and
// two-byte terminators, and all space options.
// ---------------------------------------------------------------------------
module tb_csv_record_tokenizer_top
  import crt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_AT  = 30;
  localparam int HOLD_LEN = 120;
  localparam int PHASE_ITEMS = 12;

  typedef enum logic [3:0] {
    PH_REC, PH_FIELD, PH_UNQS, PH_UNQ, PH_QUOTED, PH_AQUOTE, PH_AESC, PH_SKIP
  } parse_phase_t;

  typedef enum logic [1:0] {SRC_RAW, SRC_TERM, SRC_HELD} byte_src_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       item_valid = 1'b0;
  logic       item_stall;
  in_item_t   item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;

  // tokenizer model state
  cfg_t         pcfg = CFG_RESET;
  parse_phase_t parse_st = PH_REC;
  logic         term_held = 1'b0;
  logic         in_quotes = 1'b0;
  logic [31:0]  line_cnt = 32'd1;
  result_t      step_out[$];
  result_t      token_q[$];

  in_item_t send_q[$];
  int       queued = 0;
  int       in_count = 0;
  int       mismatch_cnt = 0;
  logic     in_xfer = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  int       win_left = 0;
  int       stall_mode = 0;
  int       stall_tick = 0;

  csv_record_tokenizer_top u_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .item_valid, .item_stall, .item,
    .result_valid, .result_stall, .result
  );

  always #5 clk = ~clk;

  // ---------------- tokenizer model ----------------

  function automatic logic two_byte_term();
    return pcfg.term_length == TERM_LEN_TWO;
  endfunction

  function automatic void put_token(input logic [7:0] b, input logic bv, input logic fe,
                                    input logic re, input logic disc, input logic err);
    result_t r;
    if (step_out.size() >= MAX_RESULTS) return;
    r.out_byte      = bv ? b : 8'd0;
    r.byte_valid    = bv;
    r.field_end     = fe;
    r.record_end    = re;
    r.field_quoted  = fe ? in_quotes : 1'b0;
    r.discard_field = disc;
    r.parse_error   = err;
    r.line_number   = line_cnt;
    r.last          = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void close_field(input logic rec);
    put_token(8'd0, 1'b0, 1'b1, rec, 1'b0, 1'b0);
    in_quotes = 1'b0;
  endfunction

  function automatic void term_as_content();
    put_token(pcfg.term_first, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    if (two_byte_term()) put_token(pcfg.term_second, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    line_cnt++;
  endfunction

  function automatic void end_record();
    close_field(1'b1);
    line_cnt++;
    parse_st = PH_REC;
  endfunction

  function automatic void raise_error();
    put_token(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    in_quotes = 1'b0;
    parse_st = PH_SKIP;
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input byte_src_t src);
    logic lit, tm, hold, q, dl, es, sp;
    lit  = src != SRC_TERM;
    tm   = src == SRC_TERM || (src == SRC_RAW && b == pcfg.term_first);
    hold = tm && src == SRC_RAW && two_byte_term();
    q    = lit && b == pcfg.quote_char;
    dl   = lit && b == pcfg.delimiter_char;
    es   = lit && b == pcfg.escape_char;
    sp   = lit && b != pcfg.delimiter_char &&
           (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_VTAB);
    if (parse_st == PH_SKIP) begin
      if (hold) term_held = 1'b1;
      else if (tm) parse_st = PH_REC;
    end else if (pcfg.escape_mode) begin
      if (parse_st == PH_AESC) begin
        if (es || dl) begin
          put_token(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
          parse_st = PH_UNQ;
        end else if (hold) begin
          term_held = 1'b1;
        end else if (tm) begin
          term_as_content();
          parse_st = PH_UNQ;
        end else begin
          parse_st = PH_UNQ;
          scan_byte(b, src);
        end
      end else if (es) begin
        parse_st = PH_AESC;
      end else if (hold) begin
        term_held = 1'b1;
      end else if (tm) begin
        end_record();
      end else if (dl) begin
        close_field(1'b0);
        parse_st = PH_FIELD;
      end else begin
        put_token(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        parse_st = PH_UNQ;
      end
    end else begin
      case (parse_st)
        PH_QUOTED: begin
          if (q) parse_st = PH_AQUOTE;
          else if (hold) term_held = 1'b1;
          else if (tm) term_as_content();
          else put_token(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        end
        PH_AQUOTE: begin
          if (sp && pcfg.space_options[0]) begin
          end else if (hold) begin
            term_held = 1'b1;
          end else if (tm) begin
            end_record();
          end else if (dl) begin
            close_field(1'b0);
            parse_st = PH_FIELD;
          end else if (q) begin
            put_token(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            parse_st = PH_QUOTED;
          end else begin
            raise_error();
          end
        end
        PH_UNQS, PH_UNQ: begin
          if (hold) begin
            term_held = 1'b1;
          end else if (tm) begin
            end_record();
          end else if (dl) begin
            close_field(1'b0);
            parse_st = PH_FIELD;
          end else if (q) begin
            if (pcfg.space_options[1] && parse_st == PH_UNQS) begin
              put_token(8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
              in_quotes = 1'b1;
              parse_st = PH_QUOTED;
            end else begin
              raise_error();
            end
          end else begin
            put_token(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            if (!sp) parse_st = PH_UNQ;
          end
        end
        default: begin
          if (q) begin
            in_quotes = 1'b1;
            parse_st = PH_QUOTED;
          end else if (dl) begin
            in_quotes = 1'b0;
            close_field(1'b0);
            parse_st = PH_FIELD;
          end else begin
            in_quotes = 1'b0;
            parse_st = PH_UNQS;
            scan_byte(b, src);
          end
        end
      endcase
    end
  endfunction

  function automatic void tokenize_item(input in_item_t it);
    result_t r;
    step_out.delete();
    if (it.end_of_input) begin
      if (term_held) begin
        term_held = 1'b0;
        scan_byte(pcfg.term_first, SRC_HELD);
      end
      if (parse_st != PH_REC && parse_st != PH_SKIP) close_field(1'b1);
      parse_st = PH_REC;
      in_quotes = 1'b0;
    end else if (term_held) begin
      term_held = 1'b0;
      if (it.data_byte == pcfg.term_second) begin
        scan_byte(it.data_byte, SRC_TERM);
      end else begin
        scan_byte(pcfg.term_first, SRC_HELD);
        scan_byte(it.data_byte, SRC_RAW);
      end
    end else begin
      scan_byte(it.data_byte, SRC_RAW);
    end
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
    foreach (step_out[i]) token_q.push_back(step_out[i]);
  endfunction

  function automatic void model_write(input logic [2:0] idx, input logic [7:0] v);
    case (idx)
      REG_DELIMITER: pcfg.delimiter_char = v;
      REG_QUOTE:     pcfg.quote_char = v;
      REG_ESCAPE:    pcfg.escape_char = v;
      REG_ESCAPE_MODE: begin
        pcfg.escape_mode = v[0];
        parse_st = PH_REC;
        term_held = 1'b0;
        in_quotes = 1'b0;
      end
      REG_TERM_FIRST: begin
        pcfg.term_first = v;
        term_held = 1'b0;
      end
      REG_TERM_SECOND: begin
        pcfg.term_second = v;
        term_held = 1'b0;
      end
      REG_TERM_LENGTH: begin
        pcfg.term_length = v[1:0];
        term_held = 1'b0;
      end
      REG_SPACE_OPTS: pcfg.space_options = v[1:0];
      default: ;
    endcase
  endfunction

  // ---------------- checking ----------------

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endfunction

  function automatic void check_token(input result_t got);
    result_t want;
    if (token_q.size() == 0) begin
      $error("result transfer with no token pending: %0h", got);
      mismatch_cnt++;
      return;
    end
    want = token_q.pop_front();
    check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
    check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
    check_field("field_end", 32'(want.field_end), 32'(got.field_end));
    check_field("record_end", 32'(want.record_end), 32'(got.record_end));
    check_field("field_quoted", 32'(want.field_quoted), 32'(got.field_quoted));
    check_field("discard_field", 32'(want.discard_field), 32'(got.discard_field));
    check_field("parse_error", 32'(want.parse_error), 32'(got.parse_error));
    check_field("line_number", want.line_number, got.line_number);
    check_field("last", 32'(want.last), 32'(got.last));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_xfer = 1'b0;
    end else begin
      in_xfer = item_valid && !item_stall;
      if (in_xfer) begin
        tokenize_item(item);
        in_count++;
      end
      if (result_valid && !result_stall) check_token(result);
    end
  end

  // ---------------- driver ----------------

  always @(negedge clk) begin
    if (!rst && (!item_valid || in_xfer)) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (send_q.size() > 0) begin
        item <= send_q.pop_front();
        item_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern in windows, plus one long hold-off
  always @(negedge clk) begin
    stall_tick++;
    if (!hold_done && in_count >= HOLD_AT) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (win_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        win_left = $urandom_range(16, 80);
      end
      win_left--;
      case (stall_mode)
        0:       result_stall <= 1'b0;
        1:       result_stall <= ($urandom_range(0, 3) == 0);
        2:       result_stall <= ($urandom_range(0, 9) < 6);
        default: result_stall <= ((stall_tick % 5) < 2);
      endcase
    end
  end

  // ---------------- stimulus ----------------

  function automatic void put_byte(input logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.end_of_input = 1'b0;
    send_q.push_back(it);
    queued++;
  endfunction

  function automatic void put_eoi();
    in_item_t it;
    it.data_byte = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    send_q.push_back(it);
    queued++;
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_term();
    put_byte(pcfg.term_first);
    if (two_byte_term()) put_byte(pcfg.term_second);
  endfunction

  function automatic logic [7:0] space_byte();
    case ($urandom_range(0, 2))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      default: return CHAR_VTAB;
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == pcfg.delimiter_char || b == pcfg.quote_char || b == pcfg.escape_char ||
           b == pcfg.term_first || b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_VTAB);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 8))
      0:       return pcfg.delimiter_char;
      1:       return pcfg.quote_char;
      2:       return pcfg.escape_char;
      3:       return pcfg.term_first;
      4:       return pcfg.term_second;
      5:       return space_byte();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_quoted_body();
    put_byte(pcfg.quote_char);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 5))
        0: begin
          put_byte(pcfg.quote_char);
          put_byte(pcfg.quote_char);
        end
        1:       put_byte(pcfg.delimiter_char);
        2:       put_term();
        default: put_byte(plain_byte());
      endcase
    end
    put_byte(pcfg.quote_char);
    if (pcfg.space_options[0] && $urandom_range(0, 1))
      repeat ($urandom_range(1, 2)) put_byte(space_byte());
  endfunction

  function automatic void add_quote_field();
    case ($urandom_range(0, 5))
      0: ;
      1, 2: begin
        repeat ($urandom_range(1, 4))
          put_byte(($urandom_range(0, 4) == 0) ? space_byte() : plain_byte());
      end
      3: add_quoted_body();
      4: begin
        repeat ($urandom_range(1, 2)) put_byte(space_byte());
        add_quoted_body();
      end
      default: repeat ($urandom_range(1, 3)) put_byte(noise_byte());
    endcase
  endfunction

  function automatic void add_escape_field();
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 6))
        0: begin
          put_byte(pcfg.escape_char);
          put_byte(pcfg.escape_char);
        end
        1: begin
          put_byte(pcfg.escape_char);
          put_byte(pcfg.delimiter_char);
        end
        2: begin
          put_byte(pcfg.escape_char);
          put_term();
        end
        3: begin
          put_byte(pcfg.escape_char);
          put_byte(plain_byte());
        end
        4:       put_byte(noise_byte());
        default: put_byte(plain_byte());
      endcase
    end
  endfunction

  function automatic void add_record();
    int nf;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) put_byte(pcfg.delimiter_char);
      if (pcfg.escape_mode) add_escape_field();
      else add_quote_field();
    end
    case ($urandom_range(0, 7))
      0:       put_eoi();
      1:       put_byte(pcfg.term_first);
      default: put_term();
    endcase
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 7) == 0) put_eoi();
      else put_byte(noise_byte());
    end
  endfunction

  task automatic add_random_items();
    int target;
    target = queued + PHASE_ITEMS;
    while (queued < target) begin
      if ($urandom_range(0, 4) == 0) add_noise();
      else add_record();
    end
  endtask

  task automatic wait_idle();
    while (send_q.size() != 0 || item_valid || token_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    model_write(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(input logic [7:0] dlm, input logic [7:0] quo, input logic [7:0] esc,
                       input logic mode, input logic [7:0] t1, input logic [7:0] t2,
                       input logic [1:0] tlen, input logic [1:0] sopt);
    wait_idle();
    write_reg(REG_DELIMITER, dlm);
    write_reg(REG_QUOTE, quo);
    write_reg(REG_ESCAPE, esc);
    write_reg(REG_ESCAPE_MODE, {7'd0, mode});
    write_reg(REG_TERM_FIRST, t1);
    write_reg(REG_TERM_SECOND, t2);
    write_reg(REG_TERM_LENGTH, {6'd0, tlen});
    write_reg(REG_SPACE_OPTS, {6'd0, sopt});
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    setup(8'h2C, 8'h22, 8'h5C, 1'b0, 8'h0A, 8'h00, 2'd1, 2'd0);
    // empty field, doubled quote and newline inside quotes, extreme bytes
    put_text(",a,\"x\"\"\n\",");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_text("\n");
    // space then quote is an error; rest of the line is dropped
    put_text(" \"k\n");
    // junk after closing quote
    put_text("\"q\"b\n");
    // end of text inside an open quote, then at record start
    put_text("\"y");
    put_eoi();
    put_eoi();
    add_random_items();

    setup(8'h09, 8'h27, 8'h5C, 1'b0, 8'h0D, 8'h0A, 2'd2, 2'd3);
    add_random_items();
    setup(8'h2C, 8'hFF, 8'h5C, 1'b1, 8'h00, 8'h0A, 2'd1, 2'd0);
    add_random_items();
    setup(8'h00, 8'h22, 8'hFF, 1'b1, 8'h0D, 8'h0A, 2'd2, 2'd3);
    add_random_items();
    setup(8'hFF, 8'h00, 8'h20, 1'b0, 8'h0A, 8'hFF, 2'd2, 2'd1);
    add_random_items();
    setup(8'h3B, 8'h22, 8'h00, 1'b0, 8'hFF, 8'h00, 2'd1, 2'd2);
    add_random_items();

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("tb_csv_record_tokenizer_top: PASS");
    end else begin
      $display("tb_csv_record_tokenizer_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_csv_record_tokenizer_top: FAIL");
    $finish;
  end

endmodule
